### src/utf8n_pkg.sv
`timescale 1ns / 1ps
// utf8n_pkg: shared types, constants and decode helpers of the utf-8 text normaliser
// no dependencies; used by the front, queue, back and top-level modules

package utf8n_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0]  ASCII_SPACE  = 8'h20;
	localparam logic [20:0] CP_SPACE     = 21'h000020;
	localparam logic [20:0] CP_IDEO_SP   = 21'h003000;
	localparam logic [20:0] CP_FW_FIRST  = 21'h00FF01;
	localparam logic [20:0] CP_FW_LAST   = 21'h00FF5E;
	localparam logic [7:0]  FW_OFFSET_LO = 8'hE0;

	localparam logic [7:0] MASK_LEAD2 = 8'hE0;
	localparam logic [7:0] MASK_LEAD3 = 8'hF0;
	localparam logic [7:0] MASK_LEAD4 = 8'hF8;
	localparam logic [7:0] LEAD2      = 8'hC0;
	localparam logic [7:0] LEAD3      = 8'hE0;
	localparam logic [7:0] LEAD4      = 8'hF0;

	// one decode job: buffered bytes (byte 0 in the low lane), byte count, end of text
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
		logic            text_end;
	} job_t;

	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	function automatic logic [2:0] seq_len(input logic [7:0] c);
		logic [2:0] l;
		l = 3'd1;
		if ((c & MASK_LEAD2) == LEAD2) l = 3'd2;
		else if ((c & MASK_LEAD3) == LEAD3) l = 3'd3;
		else if ((c & MASK_LEAD4) == LEAD4) l = 3'd4;
		return l;
	endfunction

	function automatic logic [20:0] decode(input logic [3:0][7:0] b, input logic [2:0] len);
		logic [20:0] cp;
		case (len)
			3'd2: cp = {10'd0, b[0][4:0], b[1][5:0]};
			3'd3: cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
			3'd4: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
			default: cp = b[0][7] ? 21'd0 : {13'd0, b[0]};
		endcase
		return cp;
	endfunction

	function automatic logic is_space(input logic [20:0] cp);
		return (cp == CP_SPACE) || (cp == CP_IDEO_SP);
	endfunction

	// true when the buffer holds nothing but complete space sequences
	function automatic logic all_spaces(input logic [3:0][7:0] b, input logic [2:0] cnt);
		logic [31:0] v;
		logic [2:0]  c;
		logic [2:0]  l;
		logic        ok;
		v  = b;
		c  = cnt;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (c != 3'd0) begin
				l = seq_len(v[7:0]);
				if ((c >= l) && is_space(decode(v, l))) begin
					v = v >> {l, 3'b000};
					c = c - l;
				end else begin
					ok = 1'b0;
					c  = 3'd0;
				end
			end
		end
		return ok;
	endfunction

endpackage

### src/utf8n_front.sv
`timescale 1ns / 1ps
// utf8n_front: takes input bytes, holds unfinished sequences and issues decode jobs
// depends on utf8n_pkg

module utf8n_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              text_end,
	input  utf8n_pkg::q_stat_t q_stat,
	output logic              push,
	output utf8n_pkg::job_t   job
);

	logic [2:0][7:0] pend_q;
	logic [1:0]      pend_cnt_q;
	logic [3:0][7:0] buf_w;
	logic [7:0]      head;
	logic [2:0]      cnt;
	logic            hold;
	logic            accept;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < pend_cnt_q) buf_w[i] = pend_q[i];
			else if (2'(i) == pend_cnt_q) buf_w[i] = in_byte;
			else buf_w[i] = 8'd0;
		end
		buf_w[3] = (pend_cnt_q == 2'd3) ? in_byte : 8'd0;
		head     = (pend_cnt_q == 2'd0) ? in_byte : pend_q[0];
		cnt      = {1'b0, pend_cnt_q} + 3'd1;
		// still short of a whole sequence and the text goes on
		hold     = !text_end && (cnt < utf8n_pkg::seq_len(head));
	end

	assign in_ready     = !q_stat.full;
	assign accept       = in_valid && in_ready;
	assign push         = accept && !hold;
	assign job.bytes    = buf_w;
	assign job.cnt      = cnt;
	assign job.text_end = text_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			if (hold) pend_cnt_q <= pend_cnt_q + 2'd1;
			else pend_cnt_q <= 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold) begin
			pend_q[pend_cnt_q] <= in_byte;
		end
	end

endmodule

### src/utf8n_queue.sv
`timescale 1ns / 1ps
// utf8n_queue: short job queue between the front and back parts
// depends on utf8n_pkg

module utf8n_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  utf8n_pkg::job_t    push_job,
	input  logic               pop,
	output utf8n_pkg::q_stat_t stat,
	output utf8n_pkg::job_t    head
);

	localparam int DEPTH = utf8n_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	utf8n_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.avail = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### src/utf8n_back.sv
`timescale 1ns / 1ps
// utf8n_back: works through decode jobs into the output register, one result per cycle
// while the output is not stalled; depends on utf8n_pkg

module utf8n_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fold,
	input  utf8n_pkg::q_stat_t q_stat,
	input  utf8n_pkg::job_t    q_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               run_last,
	output logic               text_done
);

	logic            w_valid_q;
	logic [3:0][7:0] w_bytes_q;
	logic [2:0]      w_cnt_q;
	logic [1:0]      w_raw_q;
	logic            w_end_q;
	logic            lws_q;

	logic            o_valid_q;
	logic [7:0]      o_byte_q;
	logic            o_bvalid_q;
	logic            o_last_q;
	logic            o_done_q;

	logic [2:0]      len;
	logic [20:0]     cp;
	logic            emit;
	logic [7:0]      e_byte;
	logic            e_bvalid;
	logic            e_space;
	logic [2:0]      shift;
	logic [1:0]      nxt_raw;
	logic            lws_n;
	logic            finish;
	logic [2:0]      nxt_cnt;
	logic [3:0][7:0] nxt_bytes;
	logic            done;
	logic            out_free;
	logic            step;
	logic            load;

	always_comb begin
		len      = utf8n_pkg::seq_len(w_bytes_q[0]);
		cp       = utf8n_pkg::decode(w_bytes_q, len);
		emit     = 1'b1;
		e_byte   = w_bytes_q[0];
		e_bvalid = 1'b1;
		e_space  = 1'b0;
		shift    = 3'd1;
		nxt_raw  = 2'd0;
		lws_n    = 1'b0;
		finish   = 1'b0;
		if (w_raw_q != 2'd0) begin
			// tail bytes of a sequence passed through raw
			nxt_raw = w_raw_q - 2'd1;
		end else if (lws_q && utf8n_pkg::all_spaces(w_bytes_q, w_cnt_q)) begin
			// whole job collapses into the running space
			finish   = 1'b1;
			emit     = w_end_q;
			e_byte   = 8'd0;
			e_bvalid = 1'b0;
			lws_n    = 1'b1;
		end else if (w_cnt_q >= len) begin
			shift = len;
			if (utf8n_pkg::is_space(cp)) begin
				emit    = !lws_q;
				e_byte  = utf8n_pkg::ASCII_SPACE;
				e_space = 1'b1;
				lws_n   = 1'b1;
			end else if (fold && (cp >= utf8n_pkg::CP_FW_FIRST)
					&& (cp <= utf8n_pkg::CP_FW_LAST)) begin
				e_byte = cp[7:0] - utf8n_pkg::FW_OFFSET_LO;
			end else begin
				shift   = 3'd1;
				nxt_raw = 2'(len - 3'd1);
			end
		end
		// a cut-off lead falls through to the defaults: lead out raw
		nxt_cnt   = w_cnt_q - shift;
		nxt_bytes = w_bytes_q >> {shift, 3'b000};
		done      = finish || (nxt_cnt == 3'd0)
			|| (emit && e_space && (nxt_raw == 2'd0)
			&& utf8n_pkg::all_spaces(nxt_bytes, nxt_cnt));
	end

	assign out_free = !o_valid_q || out_ready;
	assign step     = w_valid_q && (!emit || out_free);
	assign load     = q_stat.avail && (!w_valid_q || (step && done));
	assign pop      = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_q <= 1'b0;
			lws_q     <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (load) w_valid_q <= 1'b1;
			else if (step && done) w_valid_q <= 1'b0;
			if (step) lws_q <= (done && w_end_q) ? 1'b0 : lws_n;
			if (step && emit) o_valid_q <= 1'b1;
			else if (out_ready) o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			w_bytes_q <= q_head.bytes;
			w_cnt_q   <= q_head.cnt;
			w_raw_q   <= 2'd0;
			w_end_q   <= q_head.text_end;
		end else if (step) begin
			w_bytes_q <= nxt_bytes;
			w_cnt_q   <= nxt_cnt;
			w_raw_q   <= nxt_raw;
		end
		if (step && emit) begin
			o_byte_q   <= e_byte;
			o_bvalid_q <= e_bvalid;
			o_last_q   <= done;
			o_done_q   <= done && w_end_q;
		end
	end

	assign out_valid  = o_valid_q;
	assign out_byte   = o_byte_q;
	assign byte_valid = o_bvalid_q;
	assign run_last   = o_last_q;
	assign text_done  = o_done_q;

endmodule

### src/utf8_text_normalizer.sv
`timescale 1ns / 1ps
// throughput: one input byte per cycle while the job queue is not full; the back sequencer gives
//   one result per cycle when the output is not stalled, a raw sequence one byte per result
// reset: pending bytes, job queue, work register, space flag and output valid clear;
//   the fold register returns to 1
// depends on utf8n_pkg, utf8n_front, utf8n_queue and utf8n_back

module utf8_text_normalizer (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       fold_fullwidth,
	// input byte stream
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       text_end,
	// result stream
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       text_done
);

	// fold register: the user must write it only while the block is idle; the block does not enforce this
	logic fold_q;

	// front to queue
	logic               push;
	utf8n_pkg::job_t    push_job;
	// queue to back
	utf8n_pkg::q_stat_t q_stat;
	utf8n_pkg::job_t    q_head;
	logic               pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			fold_q <= fold_fullwidth;
		end
	end

	// front: holds bytes of an unfinished sequence, hands whole ones (or text end) on
	utf8n_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.text_end (text_end),
		.q_stat   (q_stat),
		.push     (push),
		.job      (push_job)
	);

	// short queue so the front keeps taking bytes while the back drains a burst
	utf8n_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.stat     (q_stat),
		.head     (q_head)
	);

	// back: space collapsing, fullwidth folding, raw pass-through, end marking
	utf8n_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fold       (fold_q),
		.q_stat     (q_stat),
		.q_head     (q_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.text_done  (text_done)
	);

	// end of text always closes the run of its request
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("text_done without run_last");

	// a bare end marker only ever closes a text and carries a zero byte
	a_marker_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> text_done && (out_byte == 8'd0))
		else $error("bare marker outside text end");

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("job queue overflow");

	// nothing is popped from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.avail)
		else $error("job queue underflow");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for utf8_text_normalizer; byte requests with random idling and stalls
// depends only on the normaliser rtl; expected output bytes come from a predictor kept in this file

module tb_top;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int SETTLE_CYCLES = 8;     // front-to-back latency plus a little margin
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_BYTES   = 30;    // random bytes per idling phase, at least

	localparam logic [20:0] CP_ASCII_SP = 21'h000020;
	localparam logic [20:0] CP_IDEO_SP  = 21'h003000;
	localparam logic [20:0] CP_WIDE_LO  = 21'h00FF01;
	localparam logic [20:0] CP_WIDE_HI  = 21'h00FF5E;
	localparam logic [20:0] CP_WIDE_OFS = 21'h00FEE0;
	localparam logic [7:0]  SPACE_CHAR  = 8'h20;

	localparam logic FOLD_OFF = 1'b0;
	localparam logic FOLD_ON  = 1'b1;
	localparam logic MID_TEXT = 1'b0;
	localparam logic LAST_IN_TEXT = 1'b1;

	typedef enum int {
		SEQ_ASCII,
		SEQ_SPACE,
		SEQ_IDEO_SPACE,
		SEQ_WIDE,
		SEQ_TWO,
		SEQ_THREE,
		SEQ_FOUR,
		SEQ_OVERLONG_SPACE,
		SEQ_BAD_LEAD,
		SEQ_NOISE
	} seq_kind_t;

	// one output byte as the normaliser should present it
	typedef struct packed {
		logic [7:0] data;
		logic       data_valid;
		logic       last_of_byte;
		logic       last_of_text;
	} norm_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       fold_fullwidth;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       text_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       text_done;

	// predictor state: bytes of an unfinished sequence, space-run flag, fold setting
	logic [7:0] held_bytes [3];
	int         held_count;
	logic       in_space_run;
	logic       fold_mirror;

	norm_byte_t expected_bytes [$];
	int         error_count = 0;
	int         cycle_count = 0;
	int         idle_pct;
	int         stall_pct;

	utf8_text_normalizer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.fold_fullwidth (fold_fullwidth),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.text_end       (text_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.run_last       (run_last),
		.text_done      (text_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run guard: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver side: ready re-decided at every falling edge
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99, 0) >= stall_pct);
	end

	// ---------------------------------------------------------------- predictor

	// sequence length implied by a lead byte; anything that is not a lead stands alone
	function automatic int lead_length(input logic [7:0] c);
		if (c[7] == 1'b0)       return 1;
		if (c[7:5] == 3'b110)   return 2;
		if (c[7:4] == 4'b1110)  return 3;
		if (c[7:3] == 5'b11110) return 4;
		return 1;
	endfunction

	// code point by masking only; continuation bytes are never checked
	function automatic logic [20:0] code_point(input logic [3:0][7:0] s, input int len);
		case (len)
			2: return {10'd0, s[0][4:0], s[1][5:0]};
			3: return {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
			4: return {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
			default: return s[0][7] ? 21'd0 : {13'd0, s[0]};
		endcase
	endfunction

	// works out the output bytes caused by one accepted input request
	task automatic normalise_byte(input logic [7:0] b, input logic fin);
		logic [3:0][7:0] seq;
		logic [20:0]     cp;
		logic [20:0]     folded;
		norm_byte_t      outs [4];
		int              cnt;
		int              len;
		int              used;
		int              n;
		seq = '0;
		n   = 0;
		cnt = held_count;
		for (int i = 0; i < held_count; i++)
			seq[i] = held_bytes[i];
		seq[cnt] = b;
		cnt++;
		while (cnt > 0) begin
			len = lead_length(seq[0]);
			if (cnt >= len) begin
				cp   = code_point(seq, len);
				used = len;
				if (cp == CP_ASCII_SP || cp == CP_IDEO_SP) begin
					// only the first space of a run comes out
					if (!in_space_run) begin
						outs[n] = '{SPACE_CHAR, 1'b1, 1'b0, 1'b0};
						n++;
					end
					in_space_run = 1'b1;
				end else begin
					in_space_run = 1'b0;
					if (fold_mirror && cp >= CP_WIDE_LO && cp <= CP_WIDE_HI) begin
						folded  = cp - CP_WIDE_OFS;
						outs[n] = '{folded[7:0], 1'b1, 1'b0, 1'b0};
						n++;
					end else begin
						for (int k = 0; k < len; k++) begin
							outs[n] = '{seq[k], 1'b1, 1'b0, 1'b0};
							n++;
						end
					end
				end
			end else if (fin) begin
				// cut off by end of text: lead goes out raw, the rest is decoded again
				in_space_run = 1'b0;
				outs[n] = '{seq[0], 1'b1, 1'b0, 1'b0};
				n++;
				used = 1;
			end else begin
				break;
			end
			seq = seq >> (8 * used);
			cnt -= used;
		end
		if (fin) begin
			// a silent end still reports itself with a bare marker
			if (n == 0) begin
				outs[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
				n = 1;
			end
			outs[n-1].last_of_text = 1'b1;
			held_count   = 0;
			in_space_run = 1'b0;
		end else begin
			held_count = cnt;
			for (int i = 0; i < cnt; i++)
				held_bytes[i] = seq[i];
		end
		if (n > 0)
			outs[n-1].last_of_byte = 1'b1;
		for (int i = 0; i < n; i++)
			expected_bytes.insert(expected_bytes.size(), outs[i]);
	endtask

	// ---------------------------------------------------------------- checker

	task automatic note_error(input string what);
		if (error_count < MAX_REPORTS)
			$display("mismatch %0d: %s", error_count + 1, what);
		error_count++;
	endtask

	always @(posedge clk) begin
		norm_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				note_error($sformatf("unexpected output byte %h valid %b last %b done %b",
					out_byte, byte_valid, run_last, text_done));
			end else begin
				want = expected_bytes.pop_front();
				if (out_byte !== want.data || byte_valid !== want.data_valid ||
						run_last !== want.last_of_byte || text_done !== want.last_of_text)
					note_error($sformatf(
						"byte/valid/last/done expected %h/%b/%b/%b got %h/%b/%b/%b",
						want.data, want.data_valid, want.last_of_byte, want.last_of_text,
						out_byte, byte_valid, run_last, text_done));
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// one byte request; valid stays high after acceptance so back-to-back requests need no gap
	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		while ($urandom_range(99, 0) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_byte  = b;
		text_end = fin;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		normalise_byte(b, fin);
	endtask

	// hold off new requests until every predicted byte has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only ever issued with the normaliser idle
	task automatic write_fold(input logic v);
		wait_drained();
		@(negedge clk);
		cfg_valid      = 1'b1;
		fold_fullwidth = v;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		fold_mirror = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// continuation byte: mostly well formed, sometimes anything at all
	function automatic logic [7:0] tail_byte();
		if ($urandom_range(3, 0) != 0)
			return {2'b10, 6'($urandom_range(63, 0))};
		return 8'($urandom_range(255, 0));
	endfunction

	// one random character sequence, now and then closing or cutting off the text;
	// returns the number of bytes sent
	task automatic send_random_sequence(output int sent);
		logic [3:0][7:0] s;
		logic [20:0]     cp;
		seq_kind_t       kind;
		int              len;
		int              keep;
		int              r;
		logic            fin;
		s    = '0;
		kind = seq_kind_t'($urandom_range(SEQ_NOISE, SEQ_ASCII));
		case (kind)
			SEQ_ASCII: begin
				len  = 1;
				s[0] = 8'($urandom_range(127, 0));
			end
			SEQ_SPACE: begin
				len  = 1;
				s[0] = SPACE_CHAR;
			end
			SEQ_IDEO_SPACE: begin
				len = 3;
				s   = {8'h00, 8'h80, 8'h80, 8'hE3};
			end
			SEQ_WIDE: begin
				// spans just below, through and just above the fullwidth block
				len  = 3;
				cp   = 21'h00FF00 + 21'($urandom_range(8'h60, 0));
				s[0] = {4'hE, cp[15:12]};
				s[1] = {2'b10, cp[11:6]};
				s[2] = {2'b10, cp[5:0]};
			end
			SEQ_TWO: begin
				len  = 2;
				s[0] = {3'b110, 5'($urandom_range(31, 0))};
				s[1] = tail_byte();
			end
			SEQ_THREE: begin
				len  = 3;
				s[0] = {4'b1110, 4'($urandom_range(15, 0))};
				s[1] = tail_byte();
				s[2] = tail_byte();
			end
			SEQ_FOUR: begin
				len  = 4;
				s[0] = {5'b11110, 3'($urandom_range(7, 0))};
				s[1] = tail_byte();
				s[2] = tail_byte();
				s[3] = tail_byte();
			end
			SEQ_OVERLONG_SPACE: begin
				len = $urandom_range(4, 2);
				case (len)
					2:       s = {8'h00, 8'h00, 8'hA0, 8'hC0};
					3:       s = {8'h00, 8'hA0, 8'h80, 8'hE0};
					default: s = {8'hA0, 8'h80, 8'h80, 8'hF0};
				endcase
			end
			SEQ_BAD_LEAD: begin
				len  = 1;
				s[0] = ($urandom_range(1, 0) != 0) ? 8'($urandom_range(8'hBF, 8'h80))
					: 8'($urandom_range(8'hFF, 8'hF8));
			end
			default: begin
				len  = 1;
				s[0] = 8'($urandom_range(255, 0));
			end
		endcase
		keep = len;
		fin  = MID_TEXT;
		r    = $urandom_range(99, 0);
		if (r < 8) begin
			fin = LAST_IN_TEXT;
		end else if (r < 16 && len > 1) begin
			// text ends part way through the sequence
			keep = $urandom_range(len - 1, 1);
			fin  = LAST_IN_TEXT;
		end
		for (int i = 0; i < keep; i++)
			send_byte(s[i], (i == keep - 1) ? fin : MID_TEXT);
		sent = keep;
	endtask

	// ---------------------------------------------------------------- tests

	// extremes, a range of sequence kinds and corner cases, one text after another
	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_byte(8'h00, MID_TEXT);
		send_byte(8'hFF, MID_TEXT);              // invalid lead, passes raw
		send_byte(8'h20, MID_TEXT);
		send_byte(8'h20, MID_TEXT);              // second space swallowed
		send_byte(8'hE3, MID_TEXT);              // ideographic space joins the run
		send_byte(8'h80, MID_TEXT);
		send_byte(8'h80, MID_TEXT);
		send_byte(8'h41, MID_TEXT);              // ends the run
		send_byte(8'hEF, MID_TEXT);              // first fullwidth form folds
		send_byte(8'hBC, MID_TEXT);
		send_byte(8'h81, MID_TEXT);
		send_byte(8'hEF, MID_TEXT);              // last fullwidth form folds
		send_byte(8'hBD, MID_TEXT);
		send_byte(8'h9E, MID_TEXT);
		send_byte(8'hC0, MID_TEXT);              // overlong space still counts as space
		send_byte(8'hA0, MID_TEXT);
		send_byte(8'hE3, MID_TEXT);              // cut off by end of text
		send_byte(8'h80, LAST_IN_TEXT);
		send_byte(8'h20, MID_TEXT);
		send_byte(8'h20, LAST_IN_TEXT);          // text ends on a swallowed space: bare marker
		send_byte(8'hF0, MID_TEXT);              // four bytes through raw in one burst
		send_byte(8'h9F, MID_TEXT);
		send_byte(8'h98, MID_TEXT);
		send_byte(8'h80, LAST_IN_TEXT);
	endtask

	// folding off passes fullwidth forms as raw bytes, then back on
	task automatic test_fold_setting();
		write_fold(FOLD_OFF);
		send_byte(8'hEF, MID_TEXT);
		send_byte(8'hBC, MID_TEXT);
		send_byte(8'h81, MID_TEXT);
		send_byte(8'hEF, MID_TEXT);              // one past the block, raw either way
		send_byte(8'hBD, MID_TEXT);
		send_byte(8'h9F, LAST_IN_TEXT);
		write_fold(FOLD_ON);
		send_byte(8'hEF, MID_TEXT);              // one below the block
		send_byte(8'hBC, MID_TEXT);
		send_byte(8'h80, LAST_IN_TEXT);
	endtask

	// random sequences under one idling pattern; optionally a full drain half way
	task automatic test_random_phase(input int sender_idle, input int receiver_stall,
			input logic fold, input logic pause_midway);
		int total;
		int sent;
		write_fold(fold);
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		total     = 0;
		while (total < PHASE_BYTES) begin
			send_random_sequence(sent);
			total += sent;
			if (pause_midway && total >= PHASE_BYTES / 2 && total - sent < PHASE_BYTES / 2)
				wait_drained();
		end
		// close the text so the next register write finds nothing held
		send_byte(8'($urandom_range(255, 0)), LAST_IN_TEXT);
	endtask

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		fold_fullwidth = FOLD_ON;
		in_valid       = 1'b0;
		in_byte        = 8'h00;
		text_end       = MID_TEXT;
		held_count     = 0;
		in_space_run   = 1'b0;
		fold_mirror    = FOLD_ON;
		idle_pct       = 0;
		stall_pct      = 0;
		for (int i = 0; i < 3; i++)
			held_bytes[i] = 8'h00;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fold_setting();
		test_random_phase(0, 0, FOLD_ON, 1'b0);
		test_random_phase(74, 0, FOLD_OFF, 1'b1);
		test_random_phase(0, 74, FOLD_ON, 1'b0);
		test_random_phase(6, 6, 1'($urandom_range(1, 0)), 1'b0);
		test_random_phase(0, 0, FOLD_ON, 1'b0);

		wait_drained();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
src/utf8n_pkg.sv
src/utf8n_front.sv
src/utf8n_queue.sv
src/utf8n_back.sv
src/utf8_text_normalizer.sv
sim/tb_top.sv
